// ===== sv/fcrls_pkg.sv =====
// Package for the framed command receiver / LED sequencer.
// Types, codes, command map and step ROM functions; no dependencies.
`default_nettype none
package fcrls_pkg;

  // Step ROM geometry
  localparam int unsigned STEP_ROM_DEPTH = 32;
  localparam int unsigned STEP_IDX_W     = 5;
  localparam logic [STEP_IDX_W-1:0] ROM_LEN_FIVE = 5'd12;
  localparam logic [STEP_IDX_W-1:0] ROM_LEN_SIX  = 5'd18;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Q8  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS = 1'd1;
  localparam logic [CFG_W-1:0] SPEED_RESET  = 10'd256;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 10'd500;
  localparam logic [CFG_W-1:0] SPEED_MIN    = 10'd13;
  localparam logic [CFG_W-1:0] SPEED_MAX    = 10'd512;

  // Input opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // Frame bytes
  localparam logic [7:0] BYTE_SYNC = 8'hFD;
  localparam logic [7:0] BYTE_HDR1 = 8'h03;
  localparam logic [7:0] BYTE_HDR2 = 8'hC7;
  localparam logic [7:0] BYTE_HDR3 = 8'h50;
  localparam logic [7:0] BYTE_END  = 8'hDF;

  // Command codes
  localparam logic [3:0] CMD_GO        = 4'd6;
  localparam logic [3:0] CMD_RESET     = 4'd7;
  localparam logic [3:0] CMD_HARDRESET = 4'd8;
  localparam logic [3:0] CMD_NONE      = 4'd15;

  // Frame status codes
  localparam logic [1:0] FST_NONE    = 2'd0;
  localparam logic [1:0] FST_BAD_END = 2'd1;
  localparam logic [1:0] FST_UNKNOWN = 2'd2;
  localparam logic [1:0] FST_REPEAT  = 2'd3;

  // Sequencer event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_STEPPED  = 3'd2;
  localparam logic [2:0] EV_FINISHED = 3'd3;
  localparam logic [2:0] EV_ABORTED  = 3'd4;
  localparam logic [2:0] EV_REJECTED = 3'd5;

  // Lamp colors
  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_GREEN = 2'd2;
  localparam logic [1:0] LAMP_BLUE  = 2'd3;

  // Timing limits
  localparam int unsigned MS_W      = 10;
  localparam int unsigned DWELL_W   = 11;
  localparam logic [MS_W-1:0]    SINCE_MAX = 10'd1023;
  localparam logic [DWELL_W-1:0] DWELL_MAX = 11'd2047;
  localparam logic [15:0]        COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [1:0] scenario_id;
  } fcrls_in_t;

  typedef struct packed {
    logic [1:0]  led_color;
    logic        cmd_valid;
    logic [3:0]  cmd_code;
    logic [1:0]  frame_status;
    logic [2:0]  seq_event;
    logic        running;
    logic [4:0]  step_number;
    logic        waiting_go;
    logic [15:0] commands_seen;
    logic [15:0] runs_started;
  } fcrls_out_t;

  // Dispatched command from deframer to sequencer
  typedef struct packed {
    logic       dispatch;
    logic [3:0] code;
  } fcrls_cmd_t;

  typedef struct packed {
    logic [1:0]         color;
    logic [DWELL_W-1:0] dwell;
    logic               wait_go;
  } fcrls_step_t;

  // CMD byte to command code
  function automatic logic [3:0] map_command(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      8'h82:   c = 4'd0;
      8'h88:   c = 4'd1;
      8'h81:   c = 4'd2;
      8'h84:   c = 4'd3;
      8'h8C:   c = 4'd4;
      8'h83:   c = 4'd5;
      8'h85:   c = CMD_GO;
      8'h8A:   c = CMD_RESET;
      8'h89:   c = CMD_HARDRESET;
      8'h90:   c = 4'd9;
      default: c = CMD_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [STEP_IDX_W-1:0] rom_len(input logic sel);
    return sel ? ROM_LEN_SIX : ROM_LEN_FIVE;
  endfunction

  // Step ROMs: alternating green dwell / blue wait-for-go, final step off
  function automatic fcrls_step_t step_rom(input logic sel, input logic [STEP_IDX_W-1:0] idx);
    fcrls_step_t e;
    logic [STEP_IDX_W-1:0] i;
    logic [STEP_IDX_W-1:0] last;
    i    = (32'(idx) >= STEP_ROM_DEPTH) ? '0 : idx;
    last = rom_len(sel) - 5'd1;
    if (i < last) begin
      if (i[0]) begin
        e = '{color: LAMP_BLUE, dwell: 11'd0, wait_go: 1'b1};
      end else begin
        e = '{color: LAMP_GREEN, dwell: 11'd500, wait_go: 1'b0};
      end
    end else if (i == last) begin
      e = '{color: LAMP_OFF, dwell: 11'd1000, wait_go: 1'b0};
    end else begin
      e = '{color: LAMP_OFF, dwell: 11'd0, wait_go: 1'b0};
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fcrls_deframer.sv =====
// Byte deframer, command map, repeat filter and command counter.
// Depends on fcrls_pkg.
`default_nettype none
module fcrls_deframer (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    proc_i,
  input  wire fcrls_pkg::fcrls_in_t    item_i,
  input  wire logic [9:0]              window_i,
  output fcrls_pkg::fcrls_cmd_t        cmd_o,
  output logic [1:0]                   frame_status_o,
  output logic [15:0]                  commands_seen_o
);
  import fcrls_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_HDR3 = 3'd3;
  localparam logic [2:0] PH_CMD  = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;
  localparam logic [2:0] PH_END  = 3'd6;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [3:0]      prev_q, prev_d;
  logic [MS_W-1:0] since_q, since_d;
  logic [15:0]     count_q, count_d;
  logic [7:0]      want;
  logic [3:0]      mapped;

  assign mapped = map_command(held_q);

  // expected header byte per phase
  always_comb begin
    unique case (phase_q)
      PH_HDR1: want = BYTE_HDR1;
      PH_HDR2: want = BYTE_HDR2;
      default: want = BYTE_HDR3;
    endcase
  end

  // parser and repeat filter
  always_comb begin
    phase_d        = phase_q;
    held_d         = held_q;
    prev_d         = prev_q;
    since_d        = since_q;
    count_d        = count_q;
    cmd_o          = '{dispatch: 1'b0, code: 4'd0};
    frame_status_o = FST_NONE;
    if (item_i.opcode == OP_BYTE) begin
      unique case (phase_q)
        PH_HDR1, PH_HDR2, PH_HDR3: begin
          if (item_i.rx_byte == BYTE_SYNC) begin
            phase_d = PH_HDR1;
          end else if (item_i.rx_byte == want) begin
            phase_d = phase_q + 3'd1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_CMD: begin
          held_d  = item_i.rx_byte;
          phase_d = PH_CHK;
        end
        PH_CHK: phase_d = PH_END;
        PH_END: begin
          phase_d = PH_IDLE;
          if (item_i.rx_byte != BYTE_END) begin
            frame_status_o = FST_BAD_END;
          end else if (mapped == CMD_NONE) begin
            frame_status_o = FST_UNKNOWN;
          end else if (mapped == prev_q && since_q < window_i) begin
            frame_status_o = FST_REPEAT;
          end else begin
            prev_d  = mapped;
            since_d = '0;
            if (count_q != COUNT_MAX) count_d = count_q + 16'd1;
            cmd_o   = '{dispatch: 1'b1, code: mapped};
          end
        end
        default: phase_d = (item_i.rx_byte == BYTE_SYNC) ? PH_HDR1 : PH_IDLE;
      endcase
    end else if (item_i.opcode == OP_TICK) begin
      if (since_q != SINCE_MAX) since_d = since_q + 10'd1;
    end
  end

  assign commands_seen_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      prev_q  <= CMD_NONE;
      since_q <= SINCE_MAX;
      count_q <= '0;
    end else if (proc_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      prev_q  <= prev_d;
      since_q <= since_d;
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fcrls_sequencer.sv =====
// LED step sequencer: start/stop, go and tick stepping, dwell scaling.
// Depends on fcrls_pkg (step ROM functions, codes).
`default_nettype none
module fcrls_sequencer (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  proc_i,
  input  wire fcrls_pkg::fcrls_in_t  item_i,
  input  wire fcrls_pkg::fcrls_cmd_t cmd_i,
  input  wire logic [9:0]            speed_i,
  output logic [1:0]                 led_color_o,
  output logic [2:0]                 seq_event_o,
  output logic                       running_o,
  output logic [4:0]                 step_number_o,
  output logic                       waiting_go_o,
  output logic [15:0]                runs_started_o
);
  import fcrls_pkg::*;

  logic [1:0]            lamp_q, lamp_d;
  logic                  active_q, active_d;
  logic                  tsel_q, tsel_d;
  logic [STEP_IDX_W-1:0] idx_q, idx_d;
  logic                  wait_q, wait_d;
  logic [DWELL_W-1:0]    elapsed_q, elapsed_d;
  logic [DWELL_W-1:0]    dwell_q, dwell_d;
  logic [15:0]           runs_q, runs_d;
  logic [CFG_W-1:0]      speed_q, speed_d;

  logic                  is_start;
  logic [CFG_W-1:0]      clamped;
  logic                  ld_tsel;
  logic [STEP_IDX_W-1:0] next_idx;
  logic [STEP_IDX_W-1:0] ld_idx;
  logic [CFG_W-1:0]      ld_speed;
  fcrls_step_t           ent;
  logic [20:0]           product;
  logic [12:0]           scaled;
  logic [DWELL_W-1:0]    ld_dwell;
  logic [DWELL_W-1:0]    elapsed_inc;

  // speed clamp
  always_comb begin
    if (speed_i < SPEED_MIN) begin
      clamped = SPEED_MIN;
    end else if (speed_i > SPEED_MAX) begin
      clamped = SPEED_MAX;
    end else begin
      clamped = speed_i;
    end
  end

  // one ROM read and one multiply serve both start and advance
  assign is_start = (item_i.opcode == OP_START);
  assign next_idx = idx_q + 5'd1;
  assign ld_tsel  = is_start ? item_i.scenario_id[0] : tsel_q;
  assign ld_idx   = is_start ? '0 : next_idx;
  assign ld_speed = is_start ? clamped : speed_q;
  assign ent      = step_rom(ld_tsel, ld_idx);
  assign product  = 21'(ent.dwell) * 21'(ld_speed);
  assign scaled   = product[20:8];
  assign ld_dwell = (scaled > 13'(DWELL_MAX)) ? DWELL_MAX : scaled[DWELL_W-1:0];
  assign elapsed_inc = (elapsed_q != DWELL_MAX) ? elapsed_q + 11'd1 : elapsed_q;

  // event handling
  always_comb begin
    logic do_adv;
    logic do_abort;
    do_adv      = 1'b0;
    do_abort    = 1'b0;
    lamp_d      = lamp_q;
    active_d    = active_q;
    tsel_d      = tsel_q;
    idx_d       = idx_q;
    wait_d      = wait_q;
    elapsed_d   = elapsed_q;
    dwell_d     = dwell_q;
    runs_d      = runs_q;
    speed_d     = speed_q;
    seq_event_o = EV_NONE;
    case (item_i.opcode)
      OP_BYTE: begin
        if (cmd_i.dispatch && active_q) begin
          if (wait_q && cmd_i.code == CMD_GO) begin
            do_adv = 1'b1;
          end else if (cmd_i.code == CMD_RESET || cmd_i.code == CMD_HARDRESET) begin
            do_abort = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (active_q && !wait_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= dwell_q) do_adv = 1'b1;
        end
      end
      OP_START: begin
        if (item_i.scenario_id[1]) begin
          seq_event_o = EV_REJECTED;
        end else begin
          speed_d     = clamped;
          tsel_d      = item_i.scenario_id[0];
          idx_d       = '0;
          active_d    = 1'b1;
          if (runs_q != COUNT_MAX) runs_d = runs_q + 16'd1;
          lamp_d      = ent.color;
          dwell_d     = ld_dwell;
          wait_d      = ent.wait_go;
          elapsed_d   = '0;
          seq_event_o = EV_STARTED;
        end
      end
      default: do_abort = active_q;
    endcase

    // step advance or run end
    if (do_adv) begin
      idx_d = next_idx;
      if (next_idx >= rom_len(tsel_q)) begin
        active_d    = 1'b0;
        wait_d      = 1'b0;
        seq_event_o = EV_FINISHED;
      end else begin
        lamp_d      = ent.color;
        dwell_d     = ld_dwell;
        wait_d      = ent.wait_go;
        elapsed_d   = '0;
        seq_event_o = EV_STEPPED;
      end
    end

    // abort with lamp off
    if (do_abort) begin
      active_d    = 1'b0;
      wait_d      = 1'b0;
      lamp_d      = LAMP_OFF;
      seq_event_o = EV_ABORTED;
    end
  end

  assign led_color_o    = lamp_d;
  assign running_o      = active_d;
  assign step_number_o  = active_d ? idx_d : '0;
  assign waiting_go_o   = active_d & wait_d;
  assign runs_started_o = runs_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q    <= LAMP_OFF;
      active_q  <= 1'b0;
      tsel_q    <= 1'b0;
      idx_q     <= '0;
      wait_q    <= 1'b0;
      elapsed_q <= '0;
      dwell_q   <= '0;
      runs_q    <= '0;
      speed_q   <= SPEED_RESET;
    end else if (proc_i) begin
      lamp_q    <= lamp_d;
      active_q  <= active_d;
      tsel_q    <= tsel_d;
      idx_q     <= idx_d;
      wait_q    <= wait_d;
      elapsed_q <= elapsed_d;
      dwell_q   <= dwell_d;
      runs_q    <= runs_d;
      speed_q   <= speed_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/framed_command_receiver_led_sequencer.sv =====
// A result passes the input register, then the result register; throughput is one
// item per cycle, back to back, while the output is not stalled.
// The result register drains while the input register refills; with the output
// stalled the block holds two items, one per register, before in_ready_o drops.
// Reset (rst_ni, asynchronous, low): both stages empty, parser idle, lamp off,
// counters zero, speed_q8 256, repeat window 500 ms.
`default_nettype none
module framed_command_receiver_led_sequencer (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire fcrls_pkg::fcrls_in_t   in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output fcrls_pkg::fcrls_out_t       out_data_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [fcrls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fcrls_pkg::CFG_W-1:0]     cfg_data_i
);
  import fcrls_pkg::*;

  logic             in_vld_q;
  fcrls_in_t        in_q;
  logic             out_vld_q;
  fcrls_out_t       out_q, out_d;
  logic             adv;
  logic             proc;
  logic [CFG_W-1:0] speed_q;
  logic [CFG_W-1:0] window_q;
  fcrls_cmd_t       cmd;

  // pipeline handshake
  assign adv         = !out_vld_q || out_ready_i;
  assign proc        = in_vld_q && adv;
  assign in_ready_o  = !in_vld_q || adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= SPEED_RESET;
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPEED_Q8:  speed_q  <= cfg_data_i;
        default:       window_q <= cfg_data_i;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  fcrls_deframer u_deframer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .proc_i          (proc),
    .item_i          (in_q),
    .window_i        (window_q),
    .cmd_o           (cmd),
    .frame_status_o  (out_d.frame_status),
    .commands_seen_o (out_d.commands_seen)
  );

  fcrls_sequencer u_sequencer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .proc_i         (proc),
    .item_i         (in_q),
    .cmd_i          (cmd),
    .speed_i        (speed_q),
    .led_color_o    (out_d.led_color),
    .seq_event_o    (out_d.seq_event),
    .running_o      (out_d.running),
    .step_number_o  (out_d.step_number),
    .waiting_go_o   (out_d.waiting_go),
    .runs_started_o (out_d.runs_started)
  );

  assign out_d.cmd_valid = cmd.dispatch;
  assign out_d.cmd_code  = cmd.code;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  // a processed item always lands in the result register
  a_proc_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q)
    else $error("processed item did not reach result register");

  // idle sequencer reports no step or wait
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.running |-> out_q.step_number == 5'd0 && !out_q.waiting_go)
    else $error("step fields set while not running");

  // no code without dispatch
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.cmd_valid |-> out_q.cmd_code == 4'd0)
    else $error("command code without dispatch");

  // a dispatched command carries no frame error
  a_dispatch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.cmd_valid |-> out_q.frame_status == FST_NONE)
    else $error("dispatch together with frame error");
`endif

endmodule
`default_nettype wire
